### rtl/core/srtl_pkg.sv
package srtl_pkg;

  localparam int ADDR_BITS   = 39;
  localparam int END_BITS    = ADDR_BITS + 1;
  localparam int FLAG_BITS   = 8;
  localparam int SLOT_BITS   = 4;
  localparam int COUNT_BITS  = 5;
  localparam int MAX_REGIONS = 16;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_RANGE = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [ADDR_BITS-1:0] start_address;
    logic [END_BITS-1:0]  end_address;
    logic [FLAG_BITS-1:0] access_flags;
    logic [ADDR_BITS-1:0] lookup_address;
  } in_word_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  found;
    logic                  cache_hit;
    logic [SLOT_BITS-1:0]  region_slot;
    logic [ADDR_BITS-1:0]  region_low;
    logic [END_BITS-1:0]   region_high;
    logic [FLAG_BITS-1:0]  region_perm;
    logic [COUNT_BITS-1:0] entry_count;
  } out_word_t;

  // One region as held by a cell
  typedef struct packed {
    logic [ADDR_BITS-1:0] lo;
    logic [END_BITS-1:0]  hi;
    logic [FLAG_BITS-1:0] perm;
  } region_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    region_t              new_region;
    logic [ADDR_BITS-1:0] ins_start;
    logic [END_BITS-1:0]  ins_end;
    logic [ADDR_BITS-1:0] probe;
  } cell_ctl_t;

  // Compare results returned by each cell
  typedef struct packed {
    logic start_le;
    logic end_above;
    logic start_below;
    logic covers;
  } cell_stat_t;

endpackage

### rtl/core/srtl_cell.sv
module srtl_cell #(
  parameter int IDX     = 0,
  parameter int COUNT_W = 5
) (
  input  logic                clk,
  input  logic                load,
  input  srtl_pkg::cell_ctl_t ctl,
  input  logic [COUNT_W-1:0]  pos,
  input  srtl_pkg::region_t   prev_region,
  output srtl_pkg::region_t   region,
  output srtl_pkg::cell_stat_t stat
);
  import srtl_pkg::*;

  localparam logic [COUNT_W-1:0] MY_IDX = COUNT_W'(IDX);

  region_t ent;

  // Shift up from the left neighbor above the insert point, load at it
  always_ff @(posedge clk) begin
    if (load) begin
      if (MY_IDX > pos) begin
        ent <= prev_region;
      end else if (MY_IDX == pos) begin
        ent <= ctl.new_region;
      end
    end
  end

  // Compare held region against broadcast addresses
  always_comb begin
    stat.start_le    = ent.lo <= ctl.ins_start;
    stat.end_above   = ent.hi > {1'b0, ctl.ins_start};
    stat.start_below = {1'b0, ent.lo} < ctl.ins_end;
    stat.covers      = (ent.lo <= ctl.probe) && ({1'b0, ctl.probe} < ent.hi);
  end

  assign region = ent;

endmodule

### rtl/core/sorted_region_table_lookup.sv
// Sorted region table with a one-entry lookup cache.
// Input channel in_valid/in_ready/in_data carries one word per operation:
// insert a region, look up an address, or clear the table. Output channel
// out_valid/out_ready/out_data returns exactly one result word per input.
// The table is a row of MAX_REGIONS cells; every cell compares its region
// against the broadcast addresses in the same cycle and shifts to its right
// neighbor on insert, so any operation finishes in the cycle it is taken.
// Latency: the result is registered and shows in the cycle after acceptance.
// Throughput: one word per cycle while the receiver takes each result, set by
// the cell row plus the priority select over the cells.
// The output register frees in the cycle it is taken, so a new word enters
// while the previous result is being read. When the receiver stalls, the
// result holds and in_ready drops until it is taken.
// Reset clears the region count, the cache and out_valid; cell contents are
// not cleared and are never read before they are written.
module sorted_region_table_lookup #(
  parameter int MAX_REGIONS = srtl_pkg::MAX_REGIONS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  srtl_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output srtl_pkg::out_word_t out_data
);
  import srtl_pkg::*;

  localparam int COUNT_W = $clog2(MAX_REGIONS + 1);
  localparam int IDX_W   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam logic [COUNT_W-1:0] CAP = COUNT_W'(MAX_REGIONS);

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               recent_valid;
  logic               recent_valid_next;
  logic [IDX_W-1:0]   recent_slot;
  logic [IDX_W-1:0]   recent_slot_next;
  out_word_t          result;

  cell_ctl_t  ctl;
  cell_stat_t stat [MAX_REGIONS];
  region_t    regs [MAX_REGIONS];
  logic       occ  [MAX_REGIONS];
  logic [COUNT_W-1:0] pos;
  logic [COUNT_W-1:0] pos_m1;
  logic [COUNT_W-1:0] hit_pos;
  logic               scan_hit;
  logic               cache_ok;
  logic               overlap;
  logic               accept;
  logic               load;
  kind_t              kind;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;
  assign kind     = kind_t'(in_data.kind);

  // Broadcast to the cell row
  always_comb begin
    ctl.new_region.lo   = in_data.start_address;
    ctl.new_region.hi   = in_data.end_address;
    ctl.new_region.perm = in_data.access_flags;
    ctl.ins_start       = in_data.start_address;
    ctl.ins_end         = in_data.end_address;
    ctl.probe           = in_data.lookup_address;
  end

  // Commit an insert only when it passes every check
  assign load = accept && (kind == KIND_INSERT) && (in_data.start_address <
                in_data.end_address) && !overlap && (count < CAP);

  // Cell row
  for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
    if (g == 0) begin : g_first
      srtl_cell #(.IDX(g), .COUNT_W(COUNT_W)) u_cell (
        .clk(clk), .load(load), .ctl(ctl), .pos(pos), .prev_region(ctl.new_region),
        .region(regs[g]), .stat(stat[g])
      );
    end else begin : g_rest
      srtl_cell #(.IDX(g), .COUNT_W(COUNT_W)) u_cell (
        .clk(clk), .load(load), .ctl(ctl), .pos(pos), .prev_region(regs[g-1]),
        .region(regs[g]), .stat(stat[g])
      );
    end
    assign occ[g] = COUNT_W'(g) < count;
  end

  // Insert point and first covering cell
  always_comb begin
    pos      = CAP;
    hit_pos  = '0;
    scan_hit = 1'b0;
    for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
      if (!(occ[i] && stat[i].start_le)) begin
        pos = COUNT_W'(i);
      end
      if (occ[i] && stat[i].covers) begin
        hit_pos  = COUNT_W'(i);
        scan_hit = 1'b1;
      end
    end
  end

  // Neighbor overlap check
  always_comb begin
    pos_m1  = pos - COUNT_W'(1);
    overlap = 1'b0;
    if ((pos != '0) && stat[pos_m1[IDX_W-1:0]].end_above) begin
      overlap = 1'b1;
    end
    if ((pos < count) && stat[pos[IDX_W-1:0]].start_below) begin
      overlap = 1'b1;
    end
  end

  assign cache_ok = recent_valid && (COUNT_W'(recent_slot) < count) &&
                    stat[recent_slot].covers;

  // Next state and result word
  always_comb begin
    count_next        = count;
    recent_valid_next = recent_valid;
    recent_slot_next  = recent_slot;
    result            = '0;
    unique case (kind)
      KIND_INSERT: begin
        if (!(in_data.start_address < in_data.end_address) || overlap) begin
          result.status = ST_BAD_RANGE;
        end else if (count >= CAP) begin
          result.status = ST_FULL;
        end else begin
          count_next         = count + COUNT_W'(1);
          result.status      = ST_OK;
          result.region_slot = SLOT_BITS'(pos);
          result.region_low  = in_data.start_address;
          result.region_high = in_data.end_address;
          result.region_perm = in_data.access_flags;
          if (recent_valid && (COUNT_W'(recent_slot) >= pos)) begin
            recent_slot_next = recent_slot + IDX_W'(1);
          end
        end
      end
      KIND_LOOKUP: begin
        if (cache_ok) begin
          result.status      = ST_OK;
          result.found       = 1'b1;
          result.cache_hit   = 1'b1;
          result.region_slot = SLOT_BITS'(recent_slot);
          result.region_low  = regs[recent_slot].lo;
          result.region_high = regs[recent_slot].hi;
          result.region_perm = regs[recent_slot].perm;
        end else if (scan_hit) begin
          recent_valid_next  = 1'b1;
          recent_slot_next   = hit_pos[IDX_W-1:0];
          result.status      = ST_OK;
          result.found       = 1'b1;
          result.region_slot = SLOT_BITS'(hit_pos);
          result.region_low  = regs[hit_pos[IDX_W-1:0]].lo;
          result.region_high = regs[hit_pos[IDX_W-1:0]].hi;
          result.region_perm = regs[hit_pos[IDX_W-1:0]].perm;
        end else begin
          result.status = ST_NOT_FOUND;
        end
      end
      KIND_CLEAR: begin
        count_next        = '0;
        recent_valid_next = 1'b0;
        recent_slot_next  = '0;
        result.status     = ST_OK;
      end
      default: begin
        result.status = ST_OK;
      end
    endcase
    result.entry_count = COUNT_BITS'(count_next);
  end

  // Hold state and the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      recent_valid <= 1'b0;
      recent_slot  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        count        <= count_next;
        recent_valid <= recent_valid_next;
        recent_slot  <= recent_slot_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  // Checks
  a_count_cap: assert property (@(posedge clk) disable iff (rst) count <= CAP)
    else $error("region count above capacity");

  a_cache_in_range: assert property (@(posedge clk) disable iff (rst)
    recent_valid |-> (COUNT_W'(recent_slot) < count))
    else $error("cached slot outside held regions");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_CLEAR) |=> (count == '0) && !recent_valid)
    else $error("clear left regions or cache");

  a_hit_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.cache_hit) |-> out_data.found)
    else $error("cache hit without found");

endmodule
